// ===== rtl/core/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants and types for the stream find-and-replace unit
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int MAX_REPL    = 16;
	localparam int LEN_W       = 5;
	localparam int PADDR_W     = 6;
	localparam int PDATA_W     = 64;

	// register index codes, byte address 8*index
	typedef enum logic [2:0] {
		REG_PLEN    = 3'd0,
		REG_PAT_LO  = 3'd1,
		REG_PAT_HI  = 3'd2,
		REG_RLEN    = 3'd3,
		REG_REPL_LO = 3'd4,
		REG_REPL_HI = 3'd5
	} reg_idx_t;

	// effective configuration, lengths already clamped
	typedef struct packed {
		logic [LEN_W-1:0]                 plen;
		logic [LEN_W-1:0]                 rlen;
		logic [MAX_PATTERN-1:0][7:0]      pat;
		logic [MAX_REPL-1:0][7:0]         repl;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic hit;
		logic emit_head;
		logic emit_repl;
		logic emit_mark;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic fill_gt;
		logic fill_eq;
		logic fill_one;
		logic fill_zero;
		logic hit;
		logic repl_end;
		logic rlen_zero;
		logic last;
		logic emitted;
	} sts_t;

endpackage

// ===== rtl/core/stream_find_replace_unit.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_unit
// streaming find-and-replace over a byte stream with apb-style configuration
// ----------------------------------------------------------------------------
// path: a byte's first result beat is registered from the head, replacement
//   or drain state after check, or from flush or marker after check and end
//   when the byte only flushes the window or closes the text with a marker
// flow: one byte at a time, the input stalled until the sequencer is idle
//   again, held by result beats and stalls; the single result register and the sequencer set this
// reset: arst_n clears config to defaults, empties the window and the count;
//   no clearing pass, the sequencer starts idle and can take a byte right after reset
module stream_find_replace_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0] paddr,
	input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
	output logic [sfr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// input beats
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_char,
	input  logic                        in_last,
	// result beats
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [7:0]                  out_char,
	output logic                        out_valid,
	output logic                        out_last,
	output logic [15:0]                 replace_count
);
	import sfr_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// register access never waits
	assign pready = 1'b1;

	// pattern, replacement and clamped lengths
	sfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer: one byte at a time, input stalled while it is worked on
	sfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// window, compare against the pattern, counters and result register
	sfr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.in_char       (in_char),
		.in_last       (in_last),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.out_char      (out_char),
		.out_valid     (out_valid),
		.out_last      (out_last),
		.replace_count (replace_count)
	);

	// at most one result beat is produced per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_head, cmd.emit_repl, cmd.emit_mark}))
		else $error("more than one emit command in a cycle");

	// a beat is never written over one that is still stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_head || cmd.emit_repl || cmd.emit_mark) |-> sts.slot_free)
		else $error("result register overwritten while stalled");

	// an accepted byte keeps the input stalled while it is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accept");

	// an empty marker only ever closes a text
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> out_last)
		else $error("empty marker without last");

endmodule

// ===== rtl/core/sfr_regs.sv =====
// ----------------------------------------------------------------------------
// sfr_regs
// configuration register file with apb-style access and length clamping
// ----------------------------------------------------------------------------
module sfr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0] paddr,
	input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
	output logic [sfr_pkg::PDATA_W-1:0] prdata,
	output sfr_pkg::cfg_t              cfg
);
	import sfr_pkg::*;

	logic [LEN_W-1:0]   plen_q;
	logic [LEN_W-1:0]   rlen_q;
	logic [PDATA_W-1:0] pat_lo_q;
	logic [PDATA_W-1:0] pat_hi_q;
	logic [PDATA_W-1:0] repl_lo_q;
	logic [PDATA_W-1:0] repl_hi_q;
	reg_idx_t           idx;
	logic               wr_en;

	assign idx   = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= LEN_W'(1);
			rlen_q    <= '0;
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			repl_lo_q <= '0;
			repl_hi_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PLEN:    plen_q    <= pwdata[LEN_W-1:0];
				REG_PAT_LO:  pat_lo_q  <= pwdata;
				REG_PAT_HI:  pat_hi_q  <= pwdata;
				REG_RLEN:    rlen_q    <= pwdata[LEN_W-1:0];
				REG_REPL_LO: repl_lo_q <= pwdata;
				REG_REPL_HI: repl_hi_q <= pwdata;
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PLEN:    prdata = PDATA_W'(plen_q);
			REG_PAT_LO:  prdata = pat_lo_q;
			REG_PAT_HI:  prdata = pat_hi_q;
			REG_RLEN:    prdata = PDATA_W'(rlen_q);
			REG_REPL_LO: prdata = repl_lo_q;
			REG_REPL_HI: prdata = repl_hi_q;
			default:     prdata = '0;
		endcase
	end

	// zero pattern length acts as one, oversize lengths clamp to the maximum
	always_comb begin
		if (plen_q == '0)
			cfg.plen = LEN_W'(1);
		else if (plen_q > LEN_W'(MAX_PATTERN))
			cfg.plen = LEN_W'(MAX_PATTERN);
		else
			cfg.plen = plen_q;
		if (rlen_q > LEN_W'(MAX_REPL))
			cfg.rlen = LEN_W'(MAX_REPL);
		else
			cfg.rlen = rlen_q;
		cfg.pat  = {pat_hi_q, pat_lo_q};
		cfg.repl = {repl_hi_q, repl_lo_q};
	end

endmodule

// ===== rtl/core/sfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfr_ctrl
// sequencer: accept, match check, drain, head, replacement, end, flush and marker
// ----------------------------------------------------------------------------
module sfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sfr_pkg::sts_t sts,
	output sfr_pkg::cmd_t cmd
);
	import sfr_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_DRAIN = 8'b0000_0100,
		ST_HEAD  = 8'b0000_1000,
		ST_REPL  = 8'b0001_0000,
		ST_END   = 8'b0010_0000,
		ST_FLUSH = 8'b0100_0000,
		ST_MARK  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.fill_gt) begin
					state_d = ST_DRAIN;
				end else if (sts.fill_eq) begin
					if (sts.hit) begin
						cmd.hit = 1'b1;
						state_d = sts.rlen_zero ? ST_END : ST_REPL;
					end else begin
						state_d = ST_HEAD;
					end
				end else begin
					state_d = ST_END;
				end
			end
			ST_DRAIN: begin
				// shrunk pattern: emit until pattern length minus one remain
				if (sts.slot_free) begin
					cmd.emit_head = 1'b1;
					if (sts.fill_eq)
						state_d = ST_END;
				end
			end
			ST_HEAD: begin
				if (sts.slot_free) begin
					cmd.emit_head = 1'b1;
					state_d       = ST_END;
				end
			end
			ST_REPL: begin
				if (sts.slot_free) begin
					cmd.emit_repl = 1'b1;
					if (sts.repl_end)
						state_d = ST_END;
				end
			end
			ST_END: begin
				if (!sts.last)
					state_d = ST_IDLE;
				else if (!sts.fill_zero)
					state_d = ST_FLUSH;
				else if (!sts.emitted)
					state_d = ST_MARK;
				else
					state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				if (sts.slot_free) begin
					cmd.emit_head = 1'b1;
					if (sts.fill_one)
						state_d = ST_IDLE;
				end
			end
			ST_MARK: begin
				if (sts.slot_free) begin
					cmd.emit_mark = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/sfr_dp.sv =====
// ----------------------------------------------------------------------------
// sfr_dp
// byte window, pattern compare, counters and the result register
// ----------------------------------------------------------------------------
module sfr_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  sfr_pkg::cfg_t cfg,
	input  sfr_pkg::cmd_t cmd,
	output sfr_pkg::sts_t sts,
	input  logic [7:0]    in_char,
	input  logic          in_last,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [7:0]    out_char,
	output logic          out_valid,
	output logic          out_last,
	output logic [15:0]   replace_count
);
	import sfr_pkg::*;

	localparam int RCNT_W = $clog2(MAX_REPL);
	localparam int IDX_W  = $clog2(MAX_PATTERN);

	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [LEN_W-1:0]            fill_q;
	logic [15:0]                 count_q;
	logic [RCNT_W-1:0]           rcnt_q;
	logic                        last_q;
	logic                        emitted_q;
	logic                        res_valid_q;
	logic [7:0]                  out_char_q;
	logic                        out_valid_q;
	logic                        out_last_q;
	logic [15:0]                 replace_count_q;

	logic hit;
	logic emit;
	logic final_beat;
	logic repl_end;

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((LEN_W'(i) < cfg.plen) && (win_q[i] != cfg.pat[i]))
				hit = 1'b0;
		end
	end

	assign repl_end = ((LEN_W'(rcnt_q) + LEN_W'(1)) == cfg.rlen);
	assign emit     = cmd.emit_head || cmd.emit_repl || cmd.emit_mark;

	// the beat that closes the text
	always_comb begin
		final_beat = 1'b0;
		if (cmd.emit_head)
			final_beat = last_q && (fill_q == LEN_W'(1));
		else if (cmd.emit_repl)
			final_beat = last_q && repl_end;
		else if (cmd.emit_mark)
			final_beat = 1'b1;
	end

	assign sts.slot_free = !res_valid_q || !res_stall;
	assign sts.fill_gt   = fill_q > cfg.plen;
	assign sts.fill_eq   = fill_q == cfg.plen;
	assign sts.fill_one  = fill_q == LEN_W'(1);
	assign sts.fill_zero = fill_q == '0;
	assign sts.hit       = hit;
	assign sts.repl_end  = repl_end;
	assign sts.rlen_zero = cfg.rlen == '0;
	assign sts.last      = last_q;
	assign sts.emitted   = emitted_q;

	// window storage, no reset: entries at or above the fill are never used
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[fill_q[IDX_W-1:0]] <= in_char;
		end else if (cmd.emit_head) begin
			for (int i = 0; i < MAX_PATTERN-1; i++)
				win_q[i] <= win_q[i+1];
		end
	end

	// the closing beat always leaves the window empty: a flush ends at a
	// fill of one, a replacement or a marker follows a cleared window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			count_q   <= '0;
			rcnt_q    <= '0;
			last_q    <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				fill_q    <= fill_q + LEN_W'(1);
				last_q    <= in_last;
				emitted_q <= 1'b0;
			end
			if (cmd.hit) begin
				fill_q <= '0;
				rcnt_q <= '0;
				if (count_q != 16'hFFFF)
					count_q <= count_q + 16'd1;
			end
			if (cmd.emit_head)
				fill_q <= fill_q - LEN_W'(1);
			if (cmd.emit_repl)
				rcnt_q <= rcnt_q + RCNT_W'(1);
			if (emit)
				emitted_q <= 1'b1;
			if (final_beat)
				count_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (emit)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.emit_head)
				out_char_q <= win_q[0];
			else if (cmd.emit_repl)
				out_char_q <= cfg.repl[rcnt_q];
			else
				out_char_q <= 8'd0;
			out_valid_q     <= !cmd.emit_mark;
			out_last_q      <= final_beat;
			replace_count_q <= final_beat ? count_q : 16'd0;
		end
	end

	assign res_valid     = res_valid_q;
	assign out_char      = out_char_q;
	assign out_valid     = out_valid_q;
	assign out_last      = out_last_q;
	assign replace_count = replace_count_q;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the stream find-and-replace unit: a directed table
// walks reset defaults, length clamping, full expansions and a mid-text
// pattern shrink, then random settings drive texts built from whole and
// partial pattern copies; every result beat is checked against an expected beat
// from the table or a byte-level rewrite predictor
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	// run sizing
	localparam int unsigned RANDOM_ITEMS  = 95;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	// one result beat as the block presents it
	typedef struct packed {
		logic [7:0]  ch;
		logic        vld;
		logic        lst;
		logic [15:0] cnt;
	} beat_t;

	// directed stimulus rows: a register write or a text byte
	typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [63:0] val;
		logic [7:0]  ch;
		logic        lst;
		logic        typed;
		beat_t       want;
	} row_t;

	function automatic row_t reg_row(input reg_idx_t idx, input logic [63:0] val);
		return '{kind: ROW_WRITE, idx: idx, val: val, ch: 8'h00, lst: 1'b0,
			typed: 1'b0, want: '0};
	endfunction

	function automatic row_t byte_row(input logic [7:0] c, input logic l);
		return '{kind: ROW_BYTE, idx: REG_PLEN, val: 64'h0, ch: c, lst: l,
			typed: 1'b0, want: '0};
	endfunction

	// byte whose single result beat is plain from the rules
	function automatic row_t checked_row(input logic [7:0] c, input logic l,
			input logic [7:0] wch, input logic wvld, input logic wlst,
			input logic [15:0] wcnt);
		return '{kind: ROW_BYTE, idx: REG_PLEN, val: 64'h0, ch: c, lst: l,
			typed: 1'b1, want: '{ch: wch, vld: wvld, lst: wlst, cnt: wcnt}};
	endfunction

	localparam int N_DIRECTED = 40;
	localparam row_t DIRECTED [0:N_DIRECTED-1] = '{
		// reset defaults: one-byte pattern 0x00, empty replacement
		checked_row(8'h41, 1'b1, 8'h41, 1'b1, 1'b1, 16'd0),
		// match on the last byte with nothing to emit: closing marker
		checked_row(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 16'd1),
		// zero pattern length acts as one, oversized replacement acts as 16
		reg_row(REG_PLEN, 64'h0),
		reg_row(REG_PAT_LO, 64'h0000_0000_0000_00ff),
		reg_row(REG_PAT_HI, 64'hffff_ffff_ffff_ffff),
		reg_row(REG_RLEN, 64'h0000_0000_0000_001f),
		reg_row(REG_REPL_LO, 64'h0706_0504_0302_0100),
		reg_row(REG_REPL_HI, 64'hfffe_fdfc_fbfa_f9f8),
		byte_row(8'hff, 1'b0),
		checked_row(8'h80, 1'b1, 8'h80, 1'b1, 1'b1, 16'd1),
		// oversized pattern length acts as 16, full 16-byte match
		reg_row(REG_PLEN, 64'd17),
		reg_row(REG_PAT_LO, 64'h0f1e_2d3c_4b5a_6978),
		reg_row(REG_PAT_HI, 64'h8796_a5b4_c3d2_e1f0),
		reg_row(REG_RLEN, 64'h0),
		byte_row(8'h78, 1'b0), byte_row(8'h69, 1'b0), byte_row(8'h5a, 1'b0),
		byte_row(8'h4b, 1'b0), byte_row(8'h3c, 1'b0), byte_row(8'h2d, 1'b0),
		byte_row(8'h1e, 1'b0), byte_row(8'h0f, 1'b0), byte_row(8'hf0, 1'b0),
		byte_row(8'he1, 1'b0), byte_row(8'hd2, 1'b0), byte_row(8'hc3, 1'b0),
		byte_row(8'hb4, 1'b0), byte_row(8'ha5, 1'b0), byte_row(8'h96, 1'b0),
		checked_row(8'h87, 1'b1, 8'h00, 1'b0, 1'b1, 16'd1),
		// pattern shrinks while three bytes sit in the window
		reg_row(REG_PLEN, 64'd4),
		reg_row(REG_PAT_LO, 64'h0000_0000_6463_6261),
		reg_row(REG_RLEN, 64'd2),
		reg_row(REG_REPL_LO, 64'h0000_0000_0000_5958),
		byte_row(8'h61, 1'b0), byte_row(8'h62, 1'b0), byte_row(8'h63, 1'b0),
		reg_row(REG_PLEN, 64'd2),
		byte_row(8'h64, 1'b0),
		byte_row(8'h65, 1'b1)
	};

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// block inputs, all known from time zero
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [PDATA_W-1:0] pwdata   = '0;
	logic               in_valid = 1'b0;
	logic [7:0]         in_char  = 8'h00;
	logic               in_last  = 1'b0;
	logic               res_stall = 1'b0;

	// block outputs
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_stall;
	logic               res_valid;
	logic [7:0]         out_char;
	logic               out_valid;
	logic               out_last;
	logic [15:0]        replace_count;

	stream_find_replace_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_char       (in_char),
		.in_last       (in_last),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.out_char      (out_char),
		.out_valid     (out_valid),
		.out_last      (out_last),
		.replace_count (replace_count)
	);

	// register mirror, reset values
	logic [LEN_W-1:0]            cfg_plen = 5'd1;
	logic [LEN_W-1:0]            cfg_rlen = 5'd0;
	logic [MAX_PATTERN-1:0][7:0] cfg_pat  = '0;
	logic [MAX_REPL-1:0][7:0]    cfg_repl = '0;

	// predictor state: bytes held back, replacements in the current text
	logic [7:0]  win_bytes [0:MAX_PATTERN-1];
	int unsigned win_fill  = 0;
	logic [15:0] hit_count = 16'd0;

	// beats caused by the latest byte, and the rewritten text still to arrive
	beat_t step_beats [$];
	beat_t pending_text [$];

	// bookkeeping
	int unsigned mismatches    = 0;
	int unsigned beats_checked = 0;
	int unsigned bytes_sent    = 0;
	int unsigned texts_sent    = 0;
	int unsigned settings_used = 0;
	int unsigned random_bytes  = 0;
	int unsigned widest_step   = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_calm     = 0;

	// receiver pacing
	logic        pressure_req  = 1'b0;
	bit          pressure_seen = 1'b0;
	int unsigned hold_left     = 0;
	int unsigned stall_left    = 0;
	int unsigned calm_left     = 0;
	int unsigned pick;
	beat_t       arrived_want;

	function automatic int unsigned eff_plen();
		if (cfg_plen == 0) return 1;
		if (cfg_plen > MAX_PATTERN) return MAX_PATTERN;
		return cfg_plen;
	endfunction

	function automatic beat_t text_beat(input logic [7:0] c);
		return '{ch: c, vld: 1'b1, lst: 1'b0, cnt: 16'd0};
	endfunction

	// rewrite one accepted byte into the beats it releases
	function automatic void rewrite_byte(input logic [7:0] c, input logic l);
		logic [7:0]  cand [0:MAX_PATTERN];
		int unsigned plen, rlen, n, skip, i;
		bit          hit;
		beat_t       tail;
		step_beats.delete();
		plen = eff_plen();
		rlen = (cfg_rlen > MAX_REPL) ? MAX_REPL : cfg_rlen;
		for (i = 0; i < win_fill; i++)
			cand[i] = win_bytes[i];
		cand[win_fill] = c;
		n = win_fill + 1;
		skip = 0;
		if (n > plen) begin
			// window longer than a shrunk pattern: spill the oldest, no match test
			skip = n - plen + 1;
			for (i = 0; i < skip; i++)
				step_beats.push_back(text_beat(cand[i]));
		end else if (n == plen) begin
			hit = 1'b1;
			for (i = 0; i < plen; i++)
				if (cand[i] != cfg_pat[i])
					hit = 1'b0;
			if (hit) begin
				for (i = 0; i < rlen; i++)
					step_beats.push_back(text_beat(cfg_repl[i]));
				if (hit_count != 16'hffff)
					hit_count++;
				skip = n;
			end else begin
				step_beats.push_back(text_beat(cand[0]));
				skip = 1;
			end
		end
		win_fill = n - skip;
		for (i = 0; i < win_fill; i++)
			win_bytes[i] = cand[skip + i];
		if (l) begin
			// flush, then tag the final beat with the count
			for (i = 0; i < win_fill; i++)
				step_beats.push_back(text_beat(win_bytes[i]));
			if (step_beats.size() == 0)
				step_beats.push_back('{ch: 8'h00, vld: 1'b0, lst: 1'b0, cnt: 16'd0});
			tail = step_beats.pop_back();
			tail.lst = 1'b1;
			tail.cnt = hit_count;
			step_beats.push_back(tail);
			win_fill = 0;
			hit_count = 16'd0;
		end
	endfunction

	// sender pacing: calm runs, mostly short gaps, a few long ones
	function automatic int unsigned sender_gap();
		int unsigned r;
		if (send_calm != 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send_calm = $urandom_range(5, 20);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// offer one byte, hold it until taken, then log what it should release
	task automatic send_byte(input logic [7:0] c, input logic l, input bit typed,
			input beat_t want);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		in_last  <= l;
		do @(posedge clk); while (in_stall);
		rewrite_byte(c, l);
		if (typed)
			pending_text.push_back(want);
		else
			foreach (step_beats[i])
				pending_text.push_back(step_beats[i]);
		if (step_beats.size() > widest_step)
			widest_step = step_beats.size();
		bytes_sent++;
		if (l)
			texts_sent++;
	endtask

	// drain the result side, then give a byte still in flight time to land
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup then access phase; back-to-back writes skip the idle phase
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PLEN:    cfg_plen = val[LEN_W-1:0];
			REG_PAT_LO:  cfg_pat[7:0] = val;
			REG_PAT_HI:  cfg_pat[15:8] = val;
			REG_RLEN:    cfg_rlen = val[LEN_W-1:0];
			REG_REPL_LO: cfg_repl[7:0] = val;
			REG_REPL_HI: cfg_repl[15:8] = val;
			default:     ;
		endcase
	endtask

	task automatic bus_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	task automatic configure(input logic [LEN_W-1:0] plen,
			input logic [MAX_PATTERN-1:0][7:0] pat, input logic [LEN_W-1:0] rlen,
			input logic [MAX_REPL-1:0][7:0] rep);
		wait_idle();
		write_reg(REG_PLEN, 64'(plen));
		write_reg(REG_PAT_LO, pat[7:0]);
		write_reg(REG_PAT_HI, pat[15:8]);
		write_reg(REG_RLEN, 64'(rlen));
		write_reg(REG_REPL_LO, rep[7:0]);
		write_reg(REG_REPL_HI, rep[15:8]);
		bus_release();
	endtask

	// mostly short patterns, now and then the longest and out-of-range lengths
	task automatic random_setting();
		logic [LEN_W-1:0]            plen, rlen;
		logic [MAX_PATTERN-1:0][7:0] pat;
		logic [MAX_REPL-1:0][7:0]    rep;
		logic [7:0]                  a0, a1;
		int unsigned                 r, i;
		bit                          narrow;
		r = $urandom_range(0, 9);
		if (r < 6)
			plen = LEN_W'($urandom_range(1, 5));
		else if (r < 8)
			plen = LEN_W'($urandom_range(6, 16));
		else if (r == 8)
			plen = LEN_W'(MAX_PATTERN);
		else
			plen = LEN_W'($urandom_range(0, 31));
		r = $urandom_range(0, 9);
		rlen = (r < 8) ? LEN_W'($urandom_range(0, 16)) : LEN_W'($urandom_range(0, 31));
		// a two-letter alphabet makes self-overlapping patterns and near misses
		narrow = 1'($urandom_range(0, 1));
		a0 = 8'($urandom);
		a1 = 8'($urandom);
		for (i = 0; i < MAX_PATTERN; i++)
			pat[i] = narrow ? ($urandom_range(0, 1) ? a0 : a1) : 8'($urandom);
		rep = {$urandom, $urandom, $urandom, $urandom};
		configure(plen, pat, rlen, rep);
	endtask

	// a text of whole pattern copies, broken prefixes and noise bytes
	task automatic random_text();
		logic [7:0]  text_bytes [$];
		int unsigned plen, pieces, p, kind, len, i;
		plen = eff_plen();
		pieces = $urandom_range(1, (plen > 6) ? 2 : 5);
		for (p = 0; p < pieces; p++) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				for (i = 0; i < plen; i++)
					text_bytes.push_back(cfg_pat[i]);
			end else if (kind < 6) begin
				len = $urandom_range(1, (plen > 1) ? plen - 1 : 1);
				for (i = 0; i < len; i++)
					text_bytes.push_back(cfg_pat[i]);
			end else begin
				len = $urandom_range(1, 3);
				for (i = 0; i < len; i++)
					text_bytes.push_back($urandom_range(0, 1) ?
						cfg_pat[$urandom_range(0, plen - 1)] : 8'($urandom));
			end
		end
		foreach (text_bytes[i]) begin
			send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, '0);
			random_bytes++;
		end
	endtask

	// result side: check each taken beat, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_text.size() == 0) begin
				$display("%0t ns: unexpected beat, out_char %0h out_valid %0b out_last %0b count %0h",
					$time, out_char, out_valid, out_last, replace_count);
				mismatches++;
			end else begin
				arrived_want = pending_text.pop_front();
				compare_field("out_char", 16'(arrived_want.ch), 16'(out_char));
				compare_field("out_valid", 16'(arrived_want.vld), 16'(out_valid));
				compare_field("out_last", 16'(arrived_want.lst), 16'(out_last));
				compare_field("replace_count", arrived_want.cnt, replace_count);
			end
			beats_checked++;
		end
		// one long hold-off so the block backs up into its input
		if (pressure_req && !pressure_seen) begin
			pressure_seen = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (calm_left != 0) begin
			calm_left--;
			res_stall <= 1'b0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				calm_left = $urandom_range(0, 30);
				res_stall <= 1'b0;
			end else if (pick < 92) begin
				stall_left = $urandom_range(0, 2);
				res_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(8, 40);
				res_stall <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t ns: timeout with %0d beats outstanding", $time, pending_text.size());
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin
		int row;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; writes go in only once the block has gone quiet
		for (row = 0; row < N_DIRECTED; row++) begin
			if (DIRECTED[row].kind == ROW_WRITE) begin
				if (row == 0 || DIRECTED[row-1].kind != ROW_WRITE)
					wait_idle();
				write_reg(DIRECTED[row].idx, DIRECTED[row].val);
				if (row == N_DIRECTED - 1 || DIRECTED[row+1].kind != ROW_WRITE)
					bus_release();
			end else begin
				send_byte(DIRECTED[row].ch, DIRECTED[row].lst, DIRECTED[row].typed,
					DIRECTED[row].want);
			end
		end

		// random settings and texts, with the receiver hold-off at the start
		pressure_req <= 1'b1;
		while (random_bytes < RANDOM_ITEMS) begin
			random_setting();
			repeat ($urandom_range(2, 4)) random_text();
		end

		wait_idle();
		$display("covered %0d bytes in %0d texts under %0d register settings, %0d beats checked",
			bytes_sent, texts_sent, settings_used, beats_checked);
		$display("widest expansion from one byte %0d beats; length clamps and pattern shrink hit",
			widest_step);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
